// ----- sv/sqg_pkg.sv -----
package sqg_pkg;

  // Amplitude format: signed Q2.14.
  localparam int AMP_W  = 16;
  localparam int FRAC   = 14;
  localparam int RAND_W = 16;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Command codes.
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_APPLY = 3'd1;
  localparam logic [2:0] CMD_X     = 3'd2;
  localparam logic [2:0] CMD_Z     = 3'd3;
  localparam logic [2:0] CMD_H     = 3'd4;
  localparam logic [2:0] CMD_MEAS  = 3'd5;

  // Amplitude one and 1/sqrt2 in Q2.14.
  localparam logic signed [AMP_W-1:0] AMP_ONE = 16'sd16384;
  localparam logic signed [AMP_W-1:0] AMP_H   = 16'sd11585;

  // Newton inverse square root seeds in unsigned Q1.30 and constants (three in Q4.30).
  localparam logic [30:0] SEED_LOW     = 31'd912680550;
  localparam logic [30:0] SEED_HIGH    = 31'd644245094;
  localparam logic [33:0] NEWTON_THREE = 34'd3 << 30;
  localparam logic [2:0]  NEWTON_LAST  = 3'd4;

  typedef struct packed {
    logic [2:0]              command;
    logic signed [AMP_W-1:0] m00_re;
    logic signed [AMP_W-1:0] m00_im;
    logic signed [AMP_W-1:0] m01_re;
    logic signed [AMP_W-1:0] m01_im;
    logic signed [AMP_W-1:0] m10_re;
    logic signed [AMP_W-1:0] m10_im;
    logic signed [AMP_W-1:0] m11_re;
    logic signed [AMP_W-1:0] m11_im;
    logic [RAND_W-1:0]       random_fraction;
  } cmd_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] alpha_re_out;
    logic signed [AMP_W-1:0] alpha_im_out;
    logic signed [AMP_W-1:0] beta_re_out;
    logic signed [AMP_W-1:0] beta_im_out;
    logic                    outcome;
    logic                    zero_norm;
  } res_t;

  // Operands handed to the shared multiplier.
  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

endpackage

// ----- sv/sqg_mul.sv -----
module sqg_mul (
  input  logic                               clk,
  input  sqg_pkg::mul_op_t                   op,
  output logic signed [sqg_pkg::PROD_W-1:0]  prod
);
  import sqg_pkg::*;

  // One registered signed multiply, shared by every phase of the sequencer that needs a product.
  always_ff @(posedge clk) begin
    prod <= op.a * op.b;
  end

endmodule

// ----- sv/single_qubit_gate_apply_measure_top.sv -----
// Channel  Direction  Handshake               Beat
// cmd      in         cmd_valid / cmd_ready   one command (cmd_t)
// res      out        res_valid / res_ready   state after the command (res_t)
//
// One command is worked on at a time; cmd_ready is high only while the sequencer idles.
// A gate runs the matrix apply, then like a load the zero check, sum of squares, normalizing
// shift, Newton inverse square root and scaling; every product goes through one multiplier.
// A zero norm ends the command at the zero check; an unknown command goes straight to done.
// Reset (rst, synchronous) puts the qubit in |0> and clears res_valid; res keeps its fields.
// A result waits in the output register; a stalled res_ready holds the block at its end.
module single_qubit_gate_apply_measure_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  sqg_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output sqg_pkg::res_t  res
);
  import sqg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_APPLY  = 9'b000000010,
    S_ZCHK   = 9'b000000100,
    S_SQ     = 9'b000001000,
    S_SHIFT  = 9'b000010000,
    S_NEWTON = 9'b000100000,
    S_SCALE  = 9'b001000000,
    S_MEAS   = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  // Qubit state and working registers.
  logic signed [AMP_W-1:0] amp [4];
  logic signed [AMP_W-1:0] g [8];
  logic signed [19:0]      v [4];
  logic [38:0]             n;
  logic [29:0]             m;
  logic signed [5:0]       e;
  logic [30:0]             y;
  logic [30:0]             y2;
  logic [31:0]             f;
  logic [4:0]              cnt;
  logic [2:0]              step;
  logic [1:0]              sub;
  logic                    ph;
  logic                    iss_q;
  logic [3:0]              idx_q;
  logic [RAND_W-1:0]       rnd;
  logic                    zf;
  logic                    outc;

  mul_op_t                  op;
  logic                     issue;
  logic signed [PROD_W-1:0] prod;

  sqg_mul u_mul (
    .clk  (clk),
    .op   (op),
    .prod (prod)
  );

  assign cmd_ready = (state == S_IDLE);

  // Gate matrix chosen by the incoming command.
  logic signed [AMP_W-1:0] g_next [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      g_next[i] = '0;
    end
    case (cmd.command)
      CMD_APPLY: begin
        g_next[0] = cmd.m00_re;
        g_next[1] = cmd.m00_im;
        g_next[2] = cmd.m01_re;
        g_next[3] = cmd.m01_im;
        g_next[4] = cmd.m10_re;
        g_next[5] = cmd.m10_im;
        g_next[6] = cmd.m11_re;
        g_next[7] = cmd.m11_im;
      end
      CMD_X: begin
        g_next[2] = AMP_ONE;
        g_next[4] = AMP_ONE;
      end
      CMD_Z: begin
        g_next[0] = AMP_ONE;
        g_next[6] = -AMP_ONE;
      end
      CMD_H: begin
        g_next[0] = AMP_H;
        g_next[2] = AMP_H;
        g_next[4] = AMP_H;
        g_next[6] = -AMP_H;
      end
      default: ;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    logic [2:0] gi;
    logic [1:0] ai;
    gi    = {cnt[3], cnt[1:0]};
    ai    = cnt[1:0] ^ {1'b0, cnt[2]};
    op.a  = '0;
    op.b  = '0;
    issue = 1'b0;
    unique case (state)
      S_APPLY: begin
        issue = (cnt < 5'd16);
        op.a  = MUL_W'(g[gi]);
        op.b  = MUL_W'(amp[ai]);
      end
      S_SQ: begin
        issue = (cnt < 5'd4);
        op.a  = MUL_W'(v[cnt[1:0]]);
        op.b  = MUL_W'(v[cnt[1:0]]);
      end
      S_SCALE: begin
        issue = (cnt < 5'd4);
        op.a  = MUL_W'(v[cnt[1:0]]);
        op.b  = $signed({2'b00, y});
      end
      S_MEAS: begin
        issue = (cnt < 5'd2);
        op.a  = MUL_W'(amp[{1'b0, cnt[0]}]);
        op.b  = MUL_W'(amp[{1'b0, cnt[0]}]);
      end
      S_NEWTON: begin
        case (sub)
          2'd0: begin
            op.a = $signed({2'b00, y});
            op.b = $signed({2'b00, y});
          end
          2'd1: begin
            op.a = $signed({3'b000, m});
            op.b = $signed({2'b00, y2});
          end
          default: begin
            op.a = $signed({2'b00, y});
            op.b = $signed({1'b0, f});
          end
        endcase
      end
      default: ;
    endcase
  end

  // Rounded Q2.14 product for the matrix apply (half away from zero).
  logic signed [33:0] ap_p;
  logic signed [19:0] ap_q;
  logic signed [19:0] ap_t;
  assign ap_p = prod[33:0];
  always_comb begin
    logic signed [33:0] s;
    s    = ap_p + (ap_p[33] ? 34'sd8191 : 34'sd8192);
    ap_q = 20'(s >>> FRAC);
    ap_t = (!idx_q[2] && idx_q[0]) ? -ap_q : ap_q;
  end

  // Final scaling: round v*y by 30 + e/2 bits and saturate.
  logic signed [AMP_W-1:0] sc_q;
  always_comb begin
    logic [5:0]         sh;
    logic signed [63:0] x;
    logic signed [63:0] h;
    logic signed [63:0] r;
    sh = 6'(6'sd30 + (e >>> 1));
    x  = prod[63:0];
    h  = 64'sd1 <<< (sh - 6'd1);
    r  = (x + h - (x[63] ? 64'sd1 : 64'sd0)) >>> sh;
    if (r > 64'sd32767) begin
      sc_q = 16'sh7fff;
    end else if (r < -64'sd32768) begin
      sc_q = 16'sh8000;
    end else begin
      sc_q = r[AMP_W-1:0];
    end
  end

  // Newton factor from the truncated m*y^2 term.
  logic [33:0] nt;
  assign nt = prod[61:28];

  // Measure sum of squares.
  logic [38:0] p0;
  assign p0 = n + prod[38:0];

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      amp[0]    <= AMP_ONE;
      amp[1]    <= '0;
      amp[2]    <= '0;
      amp[3]    <= '0;
      cnt       <= '0;
      iss_q     <= 1'b0;
      res_valid <= 1'b0;
      ph        <= 1'b0;
      sub       <= '0;
      step      <= '0;
      zf        <= 1'b0;
      outc      <= 1'b0;
    end else begin
      iss_q <= issue;
      idx_q <= cnt[3:0];
      if (issue) begin
        cnt <= cnt + 5'd1;
      end
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            zf   <= 1'b0;
            outc <= 1'b0;
            cnt  <= '0;
            rnd  <= cmd.random_fraction;
            for (int i = 0; i < 8; i++) begin
              g[i] <= g_next[i];
            end
            case (cmd.command)
              CMD_LOAD: begin
                v[0]  <= 20'(cmd.m00_re);
                v[1]  <= 20'(cmd.m00_im);
                v[2]  <= 20'(cmd.m10_re);
                v[3]  <= 20'(cmd.m10_im);
                state <= S_ZCHK;
              end
              CMD_APPLY: begin
                state <= S_APPLY;
              end
              CMD_X: begin
                state <= S_APPLY;
              end
              CMD_Z: begin
                state <= S_APPLY;
              end
              CMD_H: begin
                state <= S_APPLY;
              end
              CMD_MEAS: begin
                state <= S_MEAS;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_APPLY: begin
          if (iss_q) begin
            v[idx_q[3:2]] <= ((idx_q[1:0] == 2'd0) ? 20'sd0 : v[idx_q[3:2]]) + ap_t;
            if (idx_q == 4'd15) begin
              state <= S_ZCHK;
            end
          end
        end
        S_ZCHK: begin
          cnt <= '0;
          if (v[0] == 0 && v[1] == 0 && v[2] == 0 && v[3] == 0) begin
            amp[0] <= AMP_ONE;
            amp[1] <= '0;
            amp[2] <= '0;
            amp[3] <= '0;
            zf     <= 1'b1;
            state  <= S_DONE;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (iss_q) begin
            n <= ((idx_q == 4'd0) ? 39'd0 : n) + prod[38:0];
            if (idx_q == 4'd3) begin
              e     <= '0;
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          // Two bits a cycle until the leading one sits at bit 28 or 29.
          if (n[38:30] != '0) begin
            n <= n >> 2;
            e <= e + 6'sd2;
          end else if (n[29:28] == 2'b00) begin
            n <= n << 2;
            e <= e - 6'sd2;
          end else begin
            m     <= n[29:0];
            y     <= n[29] ? SEED_HIGH : SEED_LOW;
            step  <= '0;
            sub   <= '0;
            ph    <= 1'b0;
            state <= S_NEWTON;
          end
        end
        S_NEWTON: begin
          // Issue on one cycle, take the product on the next.
          if (!ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            case (sub)
              2'd0: begin
                y2  <= prod[60:30];
                sub <= 2'd1;
              end
              2'd1: begin
                f   <= (nt >= NEWTON_THREE) ? 32'd0 : 32'(NEWTON_THREE - nt);
                sub <= 2'd2;
              end
              default: begin
                y   <= prod[61:31];
                sub <= 2'd0;
                if (step == NEWTON_LAST) begin
                  cnt   <= '0;
                  state <= S_SCALE;
                end else begin
                  step <= step + 3'd1;
                end
              end
            endcase
          end
        end
        S_SCALE: begin
          if (iss_q) begin
            amp[idx_q[1:0]] <= sc_q;
            if (idx_q == 4'd3) begin
              state <= S_DONE;
            end
          end
        end
        S_MEAS: begin
          if (iss_q) begin
            if (idx_q == 4'd0) begin
              n <= prod[38:0];
            end else begin
              amp[1] <= '0;
              amp[3] <= '0;
              if ({11'd0, rnd, 12'd0} < p0) begin
                outc   <= 1'b0;
                amp[0] <= AMP_ONE;
                amp[2] <= '0;
              end else begin
                outc   <= 1'b1;
                amp[0] <= '0;
                amp[2] <= AMP_ONE;
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded as the sequencer leaves its last state.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res_ready)) begin
      res.alpha_re_out <= amp[0];
      res.alpha_im_out <= amp[1];
      res.beta_re_out  <= amp[2];
      res.beta_im_out  <= amp[3];
      res.outcome      <= outc;
      res.zero_norm    <= zf;
    end
  end

endmodule
